/* rtl/chd_pkg.sv */
// Package for the HTTP chunked body decoder: constants, status codes,
// the per-byte classification record and the header keyword table.
// No dependencies.
package chd_pkg;

  localparam int SizeBitsDef = 32;
  localparam int KeyLen      = 26;
  localparam int KeyIdxW     = 5;

  localparam logic [7:0] CharCr  = 8'h0d;
  localparam logic [7:0] CharLf  = 8'h0a;
  localparam logic [7:0] CharSp  = 8'h20;
  localparam logic [7:0] CharTab = 8'h09;
  localparam logic [7:0] CharT   = 8'h54;

  typedef enum logic [2:0] {
    StInProgress  = 3'd0,
    StComplete    = 3'd1,
    StNoHeaderEnd = 3'd2,
    StSizeCrlf    = 3'd3,
    StDataShort   = 3'd4,
    StDataCrlf    = 3'd5
  } status_e;

  typedef struct packed {
    logic       key_hit;
    logic       blank_hit;
    logic       is_t;
    logic       is_cr;
    logic       is_lf;
    logic       is_blank;
    logic       is_hex;
    logic [3:0] hex_val;
  } byte_class_t;

  // "Transfer-Encoding: chunked"
  function automatic logic [7:0] key_char(input logic [KeyIdxW-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      5'd0:    c = "T";
      5'd1:    c = "r";
      5'd2:    c = "a";
      5'd3:    c = "n";
      5'd4:    c = "s";
      5'd5:    c = "f";
      5'd6:    c = "e";
      5'd7:    c = "r";
      5'd8:    c = "-";
      5'd9:    c = "E";
      5'd10:   c = "n";
      5'd11:   c = "c";
      5'd12:   c = "o";
      5'd13:   c = "d";
      5'd14:   c = "i";
      5'd15:   c = "n";
      5'd16:   c = "g";
      5'd17:   c = ":";
      5'd18:   c = " ";
      5'd19:   c = "c";
      5'd20:   c = "h";
      5'd21:   c = "u";
      5'd22:   c = "n";
      5'd23:   c = "k";
      5'd24:   c = "e";
      5'd25:   c = "d";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* rtl/chd_in_stage.sv */
// Input register of the chunked body decoder: holds one request byte
// until the core takes it. Has no dependencies.
module chd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] data_o,
  output logic       last_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic       last_q;

  assign in_ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign last_o  = last_q;

endmodule

/* rtl/chd_byte_class.sv */
// Byte classifier: keyword and blank-line compares, whitespace, CR/LF and
// hex digit decode for the current request byte. Depends on chd_pkg.
module chd_byte_class (
  input  logic [7:0]                   data_i,
  input  logic [chd_pkg::KeyIdxW-1:0]  key_idx_i,
  input  logic [1:0]                   blank_idx_i,
  output chd_pkg::byte_class_t         cls_o
);
  import chd_pkg::*;

  logic [7:0] blank_char;

  assign blank_char = blank_idx_i[0] ? CharLf : CharCr;

  always_comb begin
    cls_o           = '0;
    cls_o.key_hit   = (data_i == key_char(key_idx_i));
    cls_o.blank_hit = (data_i == blank_char);
    cls_o.is_t      = (data_i == CharT);
    cls_o.is_cr     = (data_i == CharCr);
    cls_o.is_lf     = (data_i == CharLf);
    cls_o.is_blank  = (data_i == CharSp) || (data_i == CharTab);
    if (data_i >= "0" && data_i <= "9") begin
      cls_o.is_hex  = 1'b1;
      cls_o.hex_val = 4'(data_i - 8'h30);
    end else if (data_i >= "a" && data_i <= "f") begin
      cls_o.is_hex  = 1'b1;
      cls_o.hex_val = 4'(data_i - 8'h57);
    end else if (data_i >= "A" && data_i <= "F") begin
      cls_o.is_hex  = 1'b1;
      cls_o.hex_val = 4'(data_i - 8'h37);
    end
  end

endmodule

/* rtl/chd_core.sv */
// Decoder core: parse state machine (header, plain body, size line, chunk
// data, trailing CRLF) and the result register. Depends on chd_pkg and
// takes byte classification from chd_byte_class.
module chd_core #(
  parameter int SizeBits = chd_pkg::SizeBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [7:0]                   data_i,
  input  logic                         last_i,
  input  chd_pkg::byte_class_t         cls_i,
  output logic                         take_o,
  output logic [chd_pkg::KeyIdxW-1:0]  key_idx_o,
  output logic [1:0]                   blank_idx_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   body_byte_o,
  output logic                         byte_valid_o,
  output logic                         request_done_o,
  output logic [2:0]                   status_o
);
  import chd_pkg::*;

  typedef enum logic [2:0] {
    PhHeader, PhPlain, PhSize, PhData, PhDcr, PhDlf, PhDone, PhError
  } phase_e;

  localparam int WideBits = SizeBits + 4;
  localparam logic [WideBits-1:0] SizeLimit = {5'b0, {(SizeBits-1){1'b1}}};
  localparam logic [KeyIdxW-1:0] KeyLast = KeyIdxW'(KeyLen - 1);

  phase_e              phase_q, phase_d;
  logic [1:0]          bm_q, bm_d;
  logic [KeyIdxW-1:0]  km_q, km_d;
  logic                chunked_q, chunked_d;
  logic [SizeBits-1:0] acc_q, acc_d;
  logic                inv_q, inv_d;
  logic                crp_q, crp_d;
  logic [SizeBits-1:0] rem_q, rem_d;
  status_e             sticky_q, sticky_d;

  logic                out_valid_q;
  logic [7:0]          body_q, body_d;
  logic                bvalid_q, bvalid_d;
  logic                done_q;
  status_e             status_q, status_d;

  logic                end_line;
  logic [SizeBits-1:0] line_size;
  logic [WideBits-1:0] acc_next;
  logic [SizeBits-1:0] rem_m1;

  assign take_o      = valid_i && (!out_valid_q || out_ready_i);
  assign key_idx_o   = km_q;
  assign blank_idx_o = bm_q;

  assign acc_next  = ({4'b0, acc_q} << 4) + WideBits'(cls_i.hex_val);
  assign line_size = inv_q ? '0 : acc_q;
  assign rem_m1    = rem_q - SizeBits'(1);

  always_comb begin
    phase_d   = phase_q;
    bm_d      = bm_q;
    km_d      = km_q;
    chunked_d = chunked_q;
    acc_d     = acc_q;
    inv_d     = inv_q;
    crp_d     = crp_q;
    rem_d     = rem_q;
    sticky_d  = sticky_q;
    body_d    = 8'h00;
    bvalid_d  = 1'b0;
    status_d  = StInProgress;
    end_line  = 1'b0;

    unique case (phase_q)
      PhHeader: begin
        if (cls_i.key_hit) begin
          if (km_q == KeyLast) begin
            chunked_d = 1'b1;
            km_d      = '0;
          end else begin
            km_d = km_q + KeyIdxW'(1);
          end
        end else begin
          km_d = cls_i.is_t ? KeyIdxW'(1) : '0;
        end
        if (cls_i.blank_hit) begin
          if (bm_q == 2'd3) begin
            bm_d    = '0;
            acc_d   = '0;
            inv_d   = 1'b0;
            crp_d   = 1'b0;
            phase_d = chunked_d ? PhSize : PhPlain;
          end else begin
            bm_d = bm_q + 2'd1;
          end
        end else begin
          bm_d = cls_i.is_cr ? 2'd1 : 2'd0;
        end
      end
      PhPlain: begin
        body_d   = data_i;
        bvalid_d = 1'b1;
      end
      PhSize: begin
        if (crp_q) begin
          crp_d = 1'b0;
          if (cls_i.is_lf) begin
            end_line = 1'b1;
          end else begin
            inv_d = 1'b1;
          end
        end
        if (end_line) begin
          acc_d = '0;
          inv_d = 1'b0;
          if (line_size == '0) begin
            phase_d  = PhDone;
            sticky_d = StComplete;
          end else begin
            phase_d = PhData;
            rem_d   = line_size;
          end
        end else if (cls_i.is_cr) begin
          crp_d = 1'b1;
        end else if (cls_i.is_blank) begin
          acc_d = acc_q;
        end else if (!cls_i.is_hex) begin
          inv_d = 1'b1;
        end else if (acc_next > SizeLimit) begin
          acc_d = SizeLimit[SizeBits-1:0];
        end else begin
          acc_d = acc_next[SizeBits-1:0];
        end
      end
      PhData: begin
        body_d   = data_i;
        bvalid_d = 1'b1;
        if (rem_q != '0) begin
          rem_d = rem_m1;
          if (rem_m1 == '0) phase_d = PhDcr;
        end else begin
          phase_d = PhDcr;
        end
      end
      PhDcr: begin
        if (cls_i.is_cr) begin
          phase_d = PhDlf;
        end else begin
          phase_d  = PhError;
          sticky_d = StDataCrlf;
        end
      end
      PhDlf: begin
        if (cls_i.is_lf) begin
          acc_d   = '0;
          inv_d   = 1'b0;
          crp_d   = 1'b0;
          phase_d = PhSize;
        end else begin
          phase_d  = PhError;
          sticky_d = StDataCrlf;
        end
      end
      PhDone, PhError: begin
        phase_d = phase_q;
      end
      default: begin
        phase_d = phase_q;
      end
    endcase

    if (last_i) begin
      unique case (phase_d)
        PhHeader:     status_d = StNoHeaderEnd;
        PhPlain:      status_d = StComplete;
        PhSize:       status_d = StSizeCrlf;
        PhData:       status_d = StDataShort;
        PhDcr, PhDlf: status_d = StDataCrlf;
        default:      status_d = sticky_d;
      endcase
      phase_d   = PhHeader;
      bm_d      = '0;
      km_d      = '0;
      chunked_d = 1'b0;
      acc_d     = '0;
      inv_d     = 1'b0;
      crp_d     = 1'b0;
      rem_d     = '0;
      sticky_d  = StInProgress;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHeader;
      bm_q        <= '0;
      km_q        <= '0;
      chunked_q   <= 1'b0;
      acc_q       <= '0;
      inv_q       <= 1'b0;
      crp_q       <= 1'b0;
      rem_q       <= '0;
      sticky_q    <= StInProgress;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        phase_q   <= phase_d;
        bm_q      <= bm_d;
        km_q      <= km_d;
        chunked_q <= chunked_d;
        acc_q     <= acc_d;
        inv_q     <= inv_d;
        crp_q     <= crp_d;
        rem_q     <= rem_d;
        sticky_q  <= sticky_d;
      end
      if (!out_valid_q || out_ready_i) begin
        out_valid_q <= valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      body_q   <= body_d;
      bvalid_q <= bvalid_d;
      done_q   <= last_i;
      status_q <= status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign body_byte_o    = body_q;
  assign byte_valid_o   = bvalid_q;
  assign request_done_o = done_q;
  assign status_o       = status_q;

endmodule

/* rtl/http_chunked_body_decoder.sv */
// HTTP/1.1 chunked body decoder, one request byte in and one result out per
// clock, fully pipelined: input register, decode, result register. The result
// for a byte is written to the result register when the core takes it from
// the input register, and a new byte is taken every cycle while the result
// side keeps up. The header is scanned for CRLF CRLF and for
// "Transfer-Encoding: chunked"; without the keyword the body passes through,
// with it hex size lines (saturating at 2^(SIZE_BITS-1)-1) and chunk data are
// decoded. The result for the byte flagged last carries request_done and the
// final status, after which the block is back in its reset state.
module http_chunked_body_decoder #(
  parameter int SIZE_BITS = chd_pkg::SizeBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] body_byte_o,
  output logic       byte_valid_o,
  output logic       request_done_o,
  output logic [2:0] status_o
);
  import chd_pkg::*;

  logic               take;
  logic               stg_valid;
  logic [7:0]         stg_data;
  logic               stg_last;
  logic [KeyIdxW-1:0] key_idx;
  logic [1:0]         blank_idx;
  byte_class_t        cls;

  chd_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .take_i      (take),
    .valid_o     (stg_valid),
    .data_o      (stg_data),
    .last_o      (stg_last)
  );

  chd_byte_class u_byte_class (
    .data_i      (stg_data),
    .key_idx_i   (key_idx),
    .blank_idx_i (blank_idx),
    .cls_o       (cls)
  );

  chd_core #(
    .SizeBits (SIZE_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (stg_valid),
    .data_i         (stg_data),
    .last_i         (stg_last),
    .cls_i          (cls),
    .take_o         (take),
    .key_idx_o      (key_idx),
    .blank_idx_o    (blank_idx),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .body_byte_o    (body_byte_o),
    .byte_valid_o   (byte_valid_o),
    .request_done_o (request_done_o),
    .status_o       (status_o)
  );

endmodule
